// ===== rtl/uart_fractional_divider_solver_defines.svh =====
// Assertion macros for the fractional UART divider solver.
// Used by the port checker; no other dependencies.
`ifndef UART_FRACTIONAL_DIVIDER_SOLVER_DEFINES_SVH
`define UART_FRACTIONAL_DIVIDER_SOLVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define UFDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define UFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ufds_pkg.sv =====
// Shared types and constants of the fractional UART divider solver.
// No dependencies.
package ufds_pkg;

    // field widths
    localparam int unsigned CLK_W  = 27;
    localparam int unsigned BAUD_W = 24;
    localparam int unsigned M_W    = 10;
    localparam int unsigned N_W    = 9;

    // operand width of the shared divider: baud * 16 needs BAUD_W + 4 bits
    localparam int unsigned OP_W = BAUD_W + 4;

    // oversampling as a left shift of the baud rate
    localparam int unsigned OVS4_SHIFT  = 2;
    localparam int unsigned OVS16_SHIFT = 4;

    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(24000000);

    localparam int unsigned M_LIMIT_DEF = 1023;
    localparam int unsigned N_LIMIT_DEF = 511;

    // divider request
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] dividend;
        logic [OP_W-1:0] divisor;
    } ufds_div_req_t;

    // divider response
    typedef struct packed {
        logic            done;
        logic [OP_W-1:0] quo;
        logic [OP_W-1:0] rem;
    } ufds_div_rsp_t;

endpackage

// ===== rtl/ufds_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
// Depends on ufds_pkg.
module ufds_div
    import ufds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ufds_div_req_t req,
    output ufds_div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(OP_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [OP_W-1:0]  quo_reg;
    logic [OP_W-1:0]  rem_reg;
    logic [OP_W-1:0]  div_reg;
    logic             done_reg;

    logic [OP_W:0]    trial;
    logic             fits;
    logic [OP_W:0]    diff;

    // one trial subtraction
    assign trial = {rem_reg, quo_reg[OP_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    // control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= CNT_W'(OP_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift remainder, record quotient bit
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[OP_W-2:0], fits};
            rem_reg <= fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== rtl/uart_fractional_divider_solver.sv =====
// Fractional UART clock divider solver, top level.
// Depends on ufds_pkg and ufds_div.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the source clock in hertz (reset value
//   24 MHz). cfg_ready is high while the block is idle.
//   A request is taken on a clock edge with start high and busy low; baud_rate
//   is sampled there. busy stays high until the result is out.
//   The result (ok, mul_m, div_n, oversample_sel) is shown for exactly one
//   cycle with done high; the receiver cannot stall it, and busy falls in
//   that same cycle, so the next start can be taken on its closing edge.
// Arithmetic:
//   All arithmetic goes through one restoring divider, one quotient bit per
//   cycle. A try costs one division per Euclid step plus two for the
//   reductions; Euclid on 28-bit operands takes at most about 40 steps.
//   A request makes at most two tries, x4 oversampling first, then x16.
// Reset: asynchronous, active low; returns to idle, clock register to 24 MHz.
module uart_fractional_divider_solver
    import ufds_pkg::*;
#(
    parameter int unsigned M_LIMIT = M_LIMIT_DEF,
    parameter int unsigned N_LIMIT = N_LIMIT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CLK_W-1:0]  cfg_data,
    // request
    input  logic              start,
    output logic              busy,
    input  logic [BAUD_W-1:0] baud_rate,
    // result
    output logic              done,
    output logic              ok,
    output logic [M_W-1:0]    mul_m,
    output logic [N_W-1:0]    div_n,
    output logic              oversample_sel
);

    localparam logic [OP_W-1:0] M_LIM = OP_W'(M_LIMIT);
    localparam logic [OP_W-1:0] N_LIM = OP_W'(N_LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EUC,
        ST_WAIT_R,
        ST_WAIT_M,
        ST_ISS_N,
        ST_WAIT_N,
        ST_NEXT
    } state_t;

    state_t              state_reg;
    logic [CLK_W-1:0]    clk_hz_reg;
    logic [BAUD_W-1:0]   baud_reg;
    logic                sel_reg;
    logic [OP_W-1:0]     x_reg;
    logic [OP_W-1:0]     y_reg;
    logic [OP_W-1:0]     m_reg;
    logic                done_reg;
    logic                ok_reg;
    logic [M_W-1:0]      mul_m_reg;
    logic [N_W-1:0]      div_n_reg;
    logic                sel_out_reg;

    logic [OP_W-1:0]     clk_ext;
    logic [OP_W-1:0]     target;
    ufds_div_req_t       div_req;
    ufds_div_rsp_t       div_rsp;

    assign clk_ext = {{(OP_W-CLK_W){1'b0}}, clk_hz_reg};

    // target = baud * 4 or baud * 16
    assign target = sel_reg ? ({4'b0, baud_reg} << OVS16_SHIFT)
                            : ({4'b0, baud_reg} << OVS4_SHIFT);

    // divider issue: Euclid remainder, clk / gcd, target / gcd
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = y_reg;
        unique case (state_reg)
            ST_EUC:
            begin
                if (y_reg != '0)
                begin
                    div_req.start = 1'b1;
                end
                else
                begin
                    div_req.start    = (x_reg != '0);
                    div_req.dividend = clk_ext;
                    div_req.divisor  = x_reg;
                end
            end
            ST_ISS_N:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = target;
                div_req.divisor  = x_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    ufds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration register
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clk_hz_reg <= cfg_data;
        end
    end

    // sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            sel_reg     <= 1'b0;
            baud_reg    <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            m_reg       <= '0;
            ok_reg      <= 1'b0;
            mul_m_reg   <= '0;
            div_n_reg   <= '0;
            sel_out_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        baud_reg  <= baud_rate;
                        sel_reg   <= 1'b0;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    x_reg     <= clk_ext;
                    y_reg     <= target;
                    state_reg <= ST_EUC;
                end
                ST_EUC:
                begin
                    if (y_reg != '0)
                    begin
                        state_reg <= ST_WAIT_R;
                    end
                    else if (x_reg != '0)
                    begin
                        state_reg <= ST_WAIT_M;
                    end
                    else
                    begin
                        // zero gcd: try rejected
                        state_reg <= ST_NEXT;
                    end
                end
                ST_WAIT_R:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= div_rsp.rem;
                        state_reg <= ST_EUC;
                    end
                end
                ST_WAIT_M:
                begin
                    if (div_rsp.done)
                    begin
                        m_reg     <= div_rsp.quo;
                        state_reg <= ST_ISS_N;
                    end
                end
                ST_ISS_N:
                begin
                    state_reg <= ST_WAIT_N;
                end
                ST_WAIT_N:
                begin
                    if (div_rsp.done)
                    begin
                        if ((m_reg <= M_LIM) && (div_rsp.quo <= N_LIM))
                        begin
                            ok_reg      <= 1'b1;
                            mul_m_reg   <= m_reg[M_W-1:0];
                            div_n_reg   <= div_rsp.quo[N_W-1:0];
                            sel_out_reg <= sel_reg;
                            done_reg    <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT:
                begin
                    if (!sel_reg)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= ST_PREP;
                    end
                    else
                    begin
                        // both tries failed
                        ok_reg      <= 1'b0;
                        mul_m_reg   <= '0;
                        div_n_reg   <= '0;
                        sel_out_reg <= 1'b0;
                        done_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign mul_m          = mul_m_reg;
    assign div_n          = div_n_reg;
    assign oversample_sel = sel_out_reg;

endmodule

// ===== rtl/ufds_chk.sv =====
// Port-level checker for the fractional UART divider solver, with its bind.
// Depends on ufds_pkg and uart_fractional_divider_solver_defines.svh.
`include "uart_fractional_divider_solver_defines.svh"

module ufds_chk
    import ufds_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              ok,
    input logic [M_W-1:0]    mul_m,
    input logic [N_W-1:0]    div_n,
    input logic              oversample_sel
);

    // an accepted request occupies the block
    `UFDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

    // busy ends only with a result transfer
    `UFDS_ASSERT_NOW(a_fall_done, $fell(busy), done, "busy fell without a result")

    // a result is shown for a single cycle
    `UFDS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

    // failure reports zero fields
    `UFDS_ASSERT_NOW(a_fail_zero, done && !ok,
        (mul_m == '0) && (div_n == '0) && !oversample_sel, "failed result has nonzero fields")

endmodule

bind uart_fractional_divider_solver ufds_chk u_ufds_chk (.*);
